// File: rtl/teq_pkg.sv
// Shared constants, codes, control types and delay conversion helpers for the timer queue.
`default_nettype none

package teq_pkg;

    localparam int DEF_MAX_TIMERS = 32;
    localparam int DEF_TAG_BITS   = 16;
    localparam int DEF_TIME_BITS  = 48;

    localparam int DELAY_BITS = 32;
    localparam int PROD_BITS  = 2 * DELAY_BITS;
    localparam int SHIFT_BITS = 6;
    localparam int RESULT_CAP = 32;
    localparam int RCW        = $clog2(RESULT_CAP + 1);

    localparam logic [1:0] MODE_RESET = 2'd1;

    localparam logic [1:0] REQ_ADD_SEC = 2'd0;
    localparam logic [1:0] REQ_ADD_MS  = 2'd1;
    localparam logic [1:0] REQ_TICK    = 2'd2;

    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_FIRED  = 2'd2;
    localparam logic [1:0] KIND_IDLE   = 2'd3;

    localparam logic [1:0] MODE_1MS    = 2'd0;
    localparam logic [1:0] MODE_10MS   = 2'd1;
    localparam logic [1:0] MODE_100MS  = 2'd2;
    localparam logic [1:0] MODE_1000MS = 2'd3;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic commit;
        logic scan_rd;
        logic decide;
    } t_cmd;

    typedef struct packed {
        logic idx_last;
        logic more;
    } t_sts;

    // multiplier constant: seconds scale up, milliseconds use a reciprocal
    function automatic logic [DELAY_BITS-1:0] mul_const(input logic secs,
                                                         input logic [1:0] mode);
        logic [DELAY_BITS-1:0] k;
        k = 32'd1;
        case (mode)
            MODE_1MS:    k = secs ? 32'd1000 : 32'd1;
            MODE_10MS:   k = secs ? 32'd100  : 32'hCCCC_CCCD;
            MODE_100MS:  k = secs ? 32'd10   : 32'h51EB_851F;
            MODE_1000MS: k = secs ? 32'd1    : 32'h1062_4DD3;
            default:     k = 32'd1;
        endcase
        return k;
    endfunction

    function automatic logic [SHIFT_BITS-1:0] mul_shift(input logic secs,
                                                         input logic [1:0] mode);
        logic [SHIFT_BITS-1:0] s;
        s = 6'd0;
        case (mode)
            MODE_1MS:    s = 6'd0;
            MODE_10MS:   s = secs ? 6'd0 : 6'd35;
            MODE_100MS:  s = secs ? 6'd0 : 6'd37;
            MODE_1000MS: s = secs ? 6'd0 : 6'd38;
            default:     s = 6'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// File: rtl/timer_expiry_queue.sv
// Top level of the timer expiry queue: sequencer plus datapath.
//
// Usage: drive start with a request word (req_type, now_time, delay_value,
// timer_tag); it is taken at a clock edge where start is high and busy low.
// Each result word sits on the outputs for one cycle, flagged by o_result_valid;
// the receiver must take every word, there is no back-pressure.
// o_last_result marks the final word of a request. Request type 3 gives none.
// resolution_mode is written through i_cfg_we / i_cfg_wdata while idle.
// Add (seconds or ms): S_MUL multiplies, S_SUM adds and saturates, S_ADD commits; the
// accept or reject word is registered from the commit and shows as busy drops.
// Tick: each table scan reads one slot per cycle from the table memories, then
// passes S_LAST and S_DECIDE; a tick that fires k timers takes (k+1) scans, with
// the k-th fire word leaving at the end of scan k+1. At most 32 timers fire per
// tick. A tick with nothing due gives one idle word after one scan.
// Reset (i_rst_n low, synchronous) empties the table at once through the slot
// valid bits and sets resolution_mode to 10 ms; no clearing pass is needed.
`default_nettype none

module timer_expiry_queue #(
    parameter int MAX_TIMERS = teq_pkg::DEF_MAX_TIMERS,
    parameter int TAG_BITS   = teq_pkg::DEF_TAG_BITS,
    parameter int TIME_BITS  = teq_pkg::DEF_TIME_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [1:0]                      i_cfg_wdata,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [1:0]                      i_req_type,
    input  wire logic [TIME_BITS-1:0]            i_now_time,
    input  wire logic [teq_pkg::DELAY_BITS-1:0]  i_delay_value,
    input  wire logic [TAG_BITS-1:0]             i_timer_tag,
    output logic                                 o_result_valid,
    output logic [1:0]                           o_result_kind,
    output logic [TAG_BITS-1:0]                  o_fired_tag,
    output logic [TIME_BITS-1:0]                 o_fire_time,
    output logic                                 o_last_result
);

    teq_pkg::t_cmd w_cmd;
    teq_pkg::t_sts w_sts;

    teq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .busy       (busy)
    );

    teq_dp #(
        .MAX_TIMERS (MAX_TIMERS),
        .TAG_BITS   (TAG_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_req_type     (i_req_type),
        .i_now_time     (i_now_time),
        .i_delay_value  (i_delay_value),
        .i_timer_tag    (i_timer_tag),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_result_valid (o_result_valid),
        .o_result_kind  (o_result_kind),
        .o_fired_tag    (o_fired_tag),
        .o_fire_time    (o_fire_time),
        .o_last_result  (o_last_result)
    );

endmodule

`default_nettype wire

// File: rtl/teq_ctrl.sv
// Sequencer for the timer queue: steps adds and table scans through the datapath.
`default_nettype none

module teq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic [1:0]    i_req_type,
    input  wire teq_pkg::t_sts i_sts,
    output teq_pkg::t_cmd      o_cmd,
    output logic               busy
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MUL    = 7'b0000010,
        S_SUM    = 7'b0000100,
        S_ADD    = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_LAST   = 7'b0100000,
        S_DECIDE = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    case (i_req_type)
                        teq_pkg::REQ_ADD_SEC: n_state = S_MUL;
                        teq_pkg::REQ_ADD_MS:  n_state = S_MUL;
                        teq_pkg::REQ_TICK:    n_state = S_SCAN;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_sts.more ? S_SCAN : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/teq_dp.sv
// Datapath for the timer queue: delay conversion, timer table memories and scan selection.
`default_nettype none

module teq_dp #(
    parameter int MAX_TIMERS = teq_pkg::DEF_MAX_TIMERS,
    parameter int TAG_BITS   = teq_pkg::DEF_TAG_BITS,
    parameter int TIME_BITS  = teq_pkg::DEF_TIME_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [1:0]                      i_cfg_wdata,
    input  wire logic [1:0]                      i_req_type,
    input  wire logic [TIME_BITS-1:0]            i_now_time,
    input  wire logic [teq_pkg::DELAY_BITS-1:0]  i_delay_value,
    input  wire logic [TAG_BITS-1:0]             i_timer_tag,
    input  wire teq_pkg::t_cmd                   i_cmd,
    output teq_pkg::t_sts                        o_sts,
    output logic                                 o_result_valid,
    output logic [1:0]                           o_result_kind,
    output logic [TAG_BITS-1:0]                  o_fired_tag,
    output logic [TIME_BITS-1:0]                 o_fire_time,
    output logic                                 o_last_result
);

    localparam int IW = $clog2(MAX_TIMERS);
    localparam int CW = $clog2(MAX_TIMERS + 1);
    localparam int SW = teq_pkg::PROD_BITS + 1;

    // configuration and captured word
    logic [1:0]                      r_mode;
    logic                            r_secs;
    logic [TIME_BITS-1:0]            r_now;
    logic [teq_pkg::DELAY_BITS-1:0]  r_delay;
    logic [TAG_BITS-1:0]             r_tag;

    // add path
    logic [teq_pkg::PROD_BITS-1:0]   r_prod;
    logic [teq_pkg::PROD_BITS-1:0]   n_prod;
    logic [TIME_BITS-1:0]            r_trig;
    logic [TIME_BITS-1:0]            n_trig;
    logic [teq_pkg::PROD_BITS-1:0]   w_ticks;
    logic [SW-1:0]                   w_sum;

    // table
    logic [MAX_TIMERS-1:0]           r_valid;
    logic [CW-1:0]                   r_pend;
    logic [IW-1:0]                   n_free;
    logic                            w_full;
    logic                            w_ins;
    logic [TIME_BITS-1:0]            mem_trig [MAX_TIMERS];
    logic [TAG_BITS-1:0]             mem_tag  [MAX_TIMERS];
    logic [IW-1:0]                   mem_age  [MAX_TIMERS];
    logic [TIME_BITS-1:0]            r_rd_trig;
    logic [TAG_BITS-1:0]             r_rd_tag;
    logic [IW-1:0]                   r_rd_age;

    // scan
    logic [IW-1:0]                   r_idx;
    logic                            r_rd_vld;
    logic [IW-1:0]                   r_rd_idx;
    logic                            w_slot_v;
    logic [IW-1:0]                   w_adj_age;
    logic                            w_age_wb;
    logic                            w_age_we;
    logic [IW-1:0]                   w_age_wa;
    logic [IW-1:0]                   w_age_wd;
    logic                            w_cand;
    logic                            w_better;
    logic                            r_best_found;
    logic [TIME_BITS-1:0]            r_best_trig;
    logic [TAG_BITS-1:0]             r_best_tag;
    logic [IW-1:0]                   r_best_age;
    logic [IW-1:0]                   r_best_idx;
    logic                            r_rm_pend;
    logic [IW-1:0]                   r_rm_age;
    logic                            r_fire_pend;
    logic [TAG_BITS-1:0]             r_fire_tag;
    logic [teq_pkg::RCW-1:0]         r_cnt;
    logic                            w_more;

    // result register
    logic                            r_out_valid;
    logic [1:0]                      r_out_kind;
    logic [TAG_BITS-1:0]             r_out_tag;
    logic [TIME_BITS-1:0]            r_out_time;
    logic                            r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= teq_pkg::MODE_RESET;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_secs  <= (i_req_type == teq_pkg::REQ_ADD_SEC);
            r_now   <= i_now_time;
            r_delay <= i_delay_value;
            r_tag   <= i_timer_tag;
        end
    end

    // scale or divide the delay by a constant, then add and saturate
    always_comb begin
        n_prod  = 64'(r_delay) * 64'(teq_pkg::mul_const(r_secs, r_mode));
        w_ticks = r_prod >> teq_pkg::mul_shift(r_secs, r_mode);
        w_sum   = SW'(r_now) + SW'(w_ticks);
        if (w_sum > SW'({TIME_BITS{1'b1}})) begin
            n_trig = {TIME_BITS{1'b1}};
        end else begin
            n_trig = w_sum[TIME_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= n_prod;
        end
        if (i_cmd.sum) begin
            r_trig <= n_trig;
        end
    end

    always_comb begin
        n_free = '0;
        for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                n_free = IW'(i);
            end
        end
    end

    assign w_full = (r_pend == CW'(MAX_TIMERS));
    assign w_ins  = i_cmd.commit && !w_full;

    // scan evaluation on the registered read word
    assign w_slot_v  = r_valid[r_rd_idx];
    assign w_adj_age = r_rd_age - IW'(r_rm_pend && (r_rd_age > r_rm_age));
    assign w_age_wb  = r_rd_vld && r_rm_pend && w_slot_v;
    assign w_cand    = r_rd_vld && w_slot_v && (r_rd_trig <= r_now);
    assign w_better  = !r_best_found || (r_rd_trig < r_best_trig) ||
                       ((r_rd_trig == r_best_trig) && (w_adj_age < r_best_age));
    assign w_more    = r_best_found && (r_cnt < teq_pkg::RCW'(teq_pkg::RESULT_CAP));

    assign w_age_we = w_ins || w_age_wb;
    assign w_age_wa = w_ins ? n_free : r_rd_idx;
    assign w_age_wd = w_ins ? IW'(r_pend) : w_adj_age;

    always_ff @(posedge i_clk) begin
        if (w_ins) begin
            mem_trig[n_free] <= r_trig;
            mem_tag[n_free]  <= r_tag;
        end
        if (w_age_we) begin
            mem_age[w_age_wa] <= w_age_wd;
        end
        r_rd_trig <= mem_trig[r_idx];
        r_rd_tag  <= mem_tag[r_idx];
        r_rd_age  <= mem_age[r_idx];
        r_rd_idx  <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (w_cand && w_better) begin
            r_best_trig <= r_rd_trig;
            r_best_tag  <= r_rd_tag;
            r_best_age  <= w_adj_age;
            r_best_idx  <= r_rd_idx;
        end
        if (i_cmd.decide && w_more) begin
            r_rm_age   <= r_best_age;
            r_fire_tag <= r_best_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_pend       <= '0;
            r_idx        <= '0;
            r_rd_vld     <= 1'b0;
            r_best_found <= 1'b0;
            r_rm_pend    <= 1'b0;
            r_fire_pend  <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
            if (i_cmd.load) begin
                r_idx        <= '0;
                r_best_found <= 1'b0;
                r_rm_pend    <= 1'b0;
                r_fire_pend  <= 1'b0;
                r_cnt        <= '0;
            end
            if (i_cmd.scan_rd) begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_cand) begin
                r_best_found <= 1'b1;
            end
            if (w_ins) begin
                r_valid[n_free] <= 1'b1;
                r_pend          <= r_pend + 1'b1;
            end
            if (i_cmd.decide) begin
                r_idx        <= '0;
                r_best_found <= 1'b0;
                r_rm_pend    <= w_more;
                r_fire_pend  <= w_more;
                if (w_more) begin
                    r_valid[r_best_idx] <= 1'b0;
                    r_pend              <= r_pend - 1'b1;
                    r_cnt               <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.commit ||
                           (i_cmd.decide && (r_fire_pend || !r_best_found));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_kind <= w_full ? teq_pkg::KIND_REJECT : teq_pkg::KIND_ACCEPT;
            r_out_tag  <= '0;
            r_out_time <= '0;
            r_out_last <= 1'b1;
        end else if (i_cmd.decide) begin
            r_out_time <= r_now;
            if (r_fire_pend) begin
                r_out_kind <= teq_pkg::KIND_FIRED;
                r_out_tag  <= r_fire_tag;
                r_out_last <= !w_more;
            end else begin
                r_out_kind <= teq_pkg::KIND_IDLE;
                r_out_tag  <= '0;
                r_out_last <= 1'b1;
            end
        end
    end

    assign o_sts.idx_last = (r_idx == IW'(MAX_TIMERS - 1));
    assign o_sts.more     = w_more;

    assign o_result_valid = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_fired_tag    = r_out_tag;
    assign o_fire_time    = r_out_time;
    assign o_last_result  = r_out_last;

`ifndef SYNTHESIS
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= CW'(MAX_TIMERS))
        else $error("pending count above table size");

    a_pend_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_pend))
        else $error("pending count disagrees with valid slots");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(i_cmd.commit || i_cmd.decide))
        else $error("result strobe without commit or decide");

    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= teq_pkg::RCW'(teq_pkg::RESULT_CAP))
        else $error("tick fired more timers than the cap");

    a_rm_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rm_pend == r_fire_pend)
        else $error("age removal out of step with held fire word");
`endif

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for timer_expiry_queue: directed table, then random adds and ticks.

module tb;

    localparam int SLOTS = teq_pkg::DEF_MAX_TIMERS;
    localparam int TAGW  = teq_pkg::DEF_TAG_BITS;
    localparam int TIMEW = teq_pkg::DEF_TIME_BITS;
    localparam int DLYW  = teq_pkg::DELAY_BITS;
    localparam logic [TIMEW-1:0] TIME_MAX = '1;
    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int LIMIT  = 2_000_000;
    localparam int SETTLE = 8;
    localparam int TAIL   = 2 * (SLOTS + 2) + 10;
    localparam int PHASES = 6;
    localparam int RAND_PER_PHASE = 37;

    typedef struct packed {
        logic [1:0]       kind;
        logic [TAGW-1:0]  tag;
        logic [TIMEW-1:0] stamp;
        logic             last;
    } t_word;

    typedef struct packed {
        logic [1:0]       req;
        logic [TIMEW-1:0] now;
        logic [DLYW-1:0]  delay;
        logic [TAGW-1:0]  tag;
        logic             typed;
        t_word            want;
    } t_row;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [1:0]            cfg_wdata = teq_pkg::MODE_RESET;
    logic                  start = 1'b0;
    logic                  busy;
    logic [1:0]            req_type = teq_pkg::REQ_TICK;
    logic [TIMEW-1:0]      now_time = '0;
    logic [DLYW-1:0]       delay_value = '0;
    logic [TAGW-1:0]       timer_tag = '0;
    logic                  result_valid;
    logic [1:0]            result_kind;
    logic [TAGW-1:0]       fired_tag;
    logic [TIMEW-1:0]      fire_time;
    logic                  last_result;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    timer_expiry_queue #(
        .MAX_TIMERS(SLOTS),
        .TAG_BITS(TAGW),
        .TIME_BITS(TIMEW)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_cfg_we(cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .start(start),
        .busy(busy),
        .i_req_type(req_type),
        .i_now_time(now_time),
        .i_delay_value(delay_value),
        .i_timer_tag(timer_tag),
        .o_result_valid(result_valid),
        .o_result_kind(result_kind),
        .o_fired_tag(fired_tag),
        .o_fire_time(fire_time),
        .o_last_result(last_result)
    );

    logic [1:0]       cur_mode = teq_pkg::MODE_RESET;
    logic             tbl_valid [SLOTS];
    logic [TIMEW-1:0] tbl_trig [SLOTS];
    logic [TAGW-1:0]  tbl_tag [SLOTS];
    int               tbl_rank [SLOTS];
    int               tbl_count = 0;

    t_word owed_words [$];
    t_word fresh_words [$];
    t_row  script [$];

    logic [TIMEW-1:0] wall = '0;
    int gap_pct = 0;
    int mismatches = 0;
    int cycles = 0;
    int n_items = 0;
    int n_fired = 0;
    int n_reject = 0;
    int n_idle = 0;

    function automatic void keep_fresh(input t_word w);
        fresh_words.insert(fresh_words.size(), w);
    endfunction

    function automatic void owe_word(input t_word w);
        owed_words.insert(owed_words.size(), w);
    endfunction

    function automatic int unsigned ms_per_tick(input logic [1:0] mode);
        case (mode)
            teq_pkg::MODE_1MS:   return 1;
            teq_pkg::MODE_10MS:  return 10;
            teq_pkg::MODE_100MS: return 100;
            default:             return 1000;
        endcase
    endfunction

    task automatic book_timer(input logic [TIMEW-1:0] now, input logic [DLYW-1:0] delay,
                              input logic [TAGW-1:0] tag, input logic secs);
        logic [63:0] ticks;
        logic [63:0] trig;
        logic [63:0] factor;
        int slot;
        case (cur_mode)
            teq_pkg::MODE_1MS:   factor = 64'd1000;
            teq_pkg::MODE_10MS:  factor = 64'd100;
            teq_pkg::MODE_100MS: factor = 64'd10;
            default:             factor = 64'd1;
        endcase
        ticks = secs ? 64'(delay) * factor : 64'(delay) / 64'(ms_per_tick(cur_mode));
        trig = 64'(now) + ticks;
        if (trig > 64'(TIME_MAX)) trig = 64'(TIME_MAX);
        slot = -1;
        if (tbl_count < SLOTS) begin
            for (int i = SLOTS - 1; i >= 0; i--) begin
                if (!tbl_valid[i]) slot = i;
            end
        end
        if (slot < 0) begin
            keep_fresh('{teq_pkg::KIND_REJECT, '0, '0, 1'b1});
        end else begin
            tbl_valid[slot] = 1'b1;
            tbl_trig[slot] = trig[TIMEW-1:0];
            tbl_tag[slot] = tag;
            tbl_rank[slot] = tbl_count;
            tbl_count++;
            keep_fresh('{teq_pkg::KIND_ACCEPT, '0, '0, 1'b1});
        end
    endtask

    task automatic expire_timers(input logic [TIMEW-1:0] now);
        int n;
        int best;
        int r;
        bit done;
        n = 0;
        done = 1'b0;
        while (!done && n < teq_pkg::RESULT_CAP) begin
            best = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (tbl_valid[i] && tbl_trig[i] <= now) begin
                    if (best < 0 || tbl_trig[i] < tbl_trig[best] ||
                        (tbl_trig[i] == tbl_trig[best] && tbl_rank[i] < tbl_rank[best]))
                        best = i;
                end
            end
            if (best < 0) begin
                done = 1'b1;
            end else begin
                keep_fresh('{teq_pkg::KIND_FIRED, tbl_tag[best], now, 1'b0});
                n++;
                r = tbl_rank[best];
                tbl_valid[best] = 1'b0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_valid[i] && tbl_rank[i] > r) tbl_rank[i]--;
                end
                tbl_count--;
            end
        end
        if (n == 0)
            keep_fresh('{teq_pkg::KIND_IDLE, '0, now, 1'b1});
        else
            fresh_words[fresh_words.size() - 1].last = 1'b1;
    endtask

    function automatic void flag_word(input string what, input t_word want, input t_word got);
        if (mismatches < 10)
            $display("tb: %s: expected kind %0d tag %h time %h last %0d,",
                     what, want.kind, want.tag, want.stamp, want.last,
                     " got kind %0d tag %h time %h last %0d",
                     got.kind, got.tag, got.stamp, got.last);
        mismatches++;
    endfunction

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    always @(posedge clk) begin
        t_word got;
        t_word want;
        if (rst_n && result_valid) begin
            got = '{result_kind, fired_tag, fire_time, last_result};
            case (got.kind)
                teq_pkg::KIND_FIRED:  n_fired++;
                teq_pkg::KIND_REJECT: n_reject++;
                teq_pkg::KIND_IDLE:   n_idle++;
                default: ;
            endcase
            if (owed_words.size() == 0) begin
                flag_word("word with nothing owed", '0, got);
            end else begin
                want = owed_words[0];
                owed_words.delete(0);
                if (got.kind !== want.kind || got.tag !== want.tag ||
                    got.stamp !== want.stamp || got.last !== want.last)
                    flag_word("word mismatch", want, got);
            end
        end
    end

    task automatic send_word(input t_row r);
        start <= 1'b1;
        req_type <= r.req;
        now_time <= r.now;
        delay_value <= r.delay;
        timer_tag <= r.tag;
        @(posedge clk);
        while (busy) @(posedge clk);
        fresh_words.delete();
        case (r.req)
            teq_pkg::REQ_ADD_SEC: book_timer(r.now, r.delay, r.tag, 1'b1);
            teq_pkg::REQ_ADD_MS:  book_timer(r.now, r.delay, r.tag, 1'b0);
            teq_pkg::REQ_TICK:    expire_timers(r.now);
            default: ;
        endcase
        if (r.typed)
            owe_word(r.want);
        else
            foreach (fresh_words[i]) owe_word(fresh_words[i]);
        n_items++;
    endtask

    task automatic maybe_gap();
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (owed_words.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic set_mode(input logic [1:0] mode);
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_mode = mode;
    endtask

    task automatic put_row(input logic [1:0] req, input logic [TIMEW-1:0] now,
                           input logic [DLYW-1:0] delay, input logic [TAGW-1:0] tag,
                           input logic typed, input logic [1:0] kind,
                           input logic [TIMEW-1:0] stamp);
        t_row r;
        r.req = req;
        r.now = now;
        r.delay = delay;
        r.tag = tag;
        r.typed = typed;
        r.want = '{kind, '0, stamp, 1'b1};
        script.insert(script.size(), r);
    endtask

    task automatic make_random(output t_row r);
        int pick;
        int unsigned div;
        r = '0;
        div = ms_per_tick(cur_mode);
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0)
            wall = TIMEW'({$urandom, $urandom});
        else
            wall = wall + $urandom_range(0, 40);
        r.now = wall;
        r.tag = TAGW'($urandom);
        r.delay = $urandom;
        if (pick < 45) begin
            if ($urandom_range(0, 1)) begin
                r.req = teq_pkg::REQ_ADD_SEC;
                if ($urandom_range(0, 9) != 0) r.delay = $urandom_range(0, 2);
            end else begin
                r.req = teq_pkg::REQ_ADD_MS;
                if ($urandom_range(0, 9) != 0)
                    r.delay = $urandom_range(0, 60) * div + $urandom_range(0, div - 1);
            end
        end else if (pick < 88) begin
            r.req = teq_pkg::REQ_TICK;
            case ($urandom_range(0, 24))
                0, 1: r.now = wall - $urandom_range(0, 30);
                2:    r.now = TIME_MAX;
                default: ;
            endcase
        end else if (pick < 93) begin
            r.req = REQ_NONE;
            r.now = TIMEW'({$urandom, $urandom});
        end else begin
            r.req = $urandom_range(0, 1) ? teq_pkg::REQ_ADD_SEC : teq_pkg::REQ_ADD_MS;
            r.now = TIMEW'({$urandom, $urandom});
        end
    endtask

    task automatic fill_table();
        t_row r;
        r = '0;
        r.req = teq_pkg::REQ_TICK;
        r.now = TIME_MAX;
        send_word(r);
        maybe_gap();
        for (int i = 0; i < SLOTS + 2; i++) begin
            r.req = $urandom_range(0, 1) ? teq_pkg::REQ_ADD_SEC : teq_pkg::REQ_ADD_MS;
            r.now = wall;
            r.delay = '0;
            r.tag = TAGW'($urandom);
            send_word(r);
            maybe_gap();
        end
        r.req = teq_pkg::REQ_TICK;
        r.now = wall;
        send_word(r);
        maybe_gap();
    endtask

    initial begin
        logic [1:0] phase_mode [PHASES];
        int phase_gap [PHASES];
        t_row r;
        phase_mode = '{teq_pkg::MODE_1MS, teq_pkg::MODE_1000MS, teq_pkg::MODE_100MS,
                       teq_pkg::MODE_10MS, teq_pkg::MODE_1MS, teq_pkg::MODE_1000MS};
        phase_gap = '{35, 0, 60, 25, 40, 0};
        for (int i = 0; i < SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_rank[i] = 0;
        end

        put_row(teq_pkg::REQ_TICK,    '0,             '0,           '0,       1,
                teq_pkg::KIND_IDLE, '0);
        put_row(teq_pkg::REQ_TICK,    TIME_MAX,       '0,           '0,       1,
                teq_pkg::KIND_IDLE, TIME_MAX);
        put_row(teq_pkg::REQ_ADD_SEC, '0,             '0,           '0,       1,
                teq_pkg::KIND_ACCEPT, '0);
        put_row(teq_pkg::REQ_ADD_MS,  TIME_MAX,       32'hFFFFFFFF, 16'hFFFF, 1,
                teq_pkg::KIND_ACCEPT, '0);
        put_row(teq_pkg::REQ_ADD_SEC, TIME_MAX - 999, 32'hFFFFFFFF, 16'h1234, 1,
                teq_pkg::KIND_ACCEPT, '0);
        put_row(teq_pkg::REQ_ADD_MS,  48'd100,        32'd9,        16'h0055, 1,
                teq_pkg::KIND_ACCEPT, '0);
        put_row(teq_pkg::REQ_ADD_SEC, 48'd100,        32'd0,        16'h00AA, 0,
                teq_pkg::KIND_ACCEPT, '0);
        put_row(teq_pkg::REQ_ADD_MS,  48'd50,         32'd10,       16'h0101, 0,
                teq_pkg::KIND_ACCEPT, '0);
        put_row(teq_pkg::REQ_ADD_MS,  48'd1000,       32'd12345,    16'h0B0B, 0,
                teq_pkg::KIND_ACCEPT, '0);
        put_row(teq_pkg::REQ_ADD_SEC, '0,             32'd5,        16'h0C0C, 0,
                teq_pkg::KIND_ACCEPT, '0);
        put_row(teq_pkg::REQ_TICK,    48'd99,         '0,           '0,       0,
                teq_pkg::KIND_FIRED, '0);
        put_row(teq_pkg::REQ_TICK,    48'd100,        '0,           '0,       0,
                teq_pkg::KIND_FIRED, '0);
        put_row(teq_pkg::REQ_TICK,    48'd50,         '0,           '0,       1,
                teq_pkg::KIND_IDLE, 48'd50);
        put_row(REQ_NONE,             TIME_MAX,       32'hFFFFFFFF, 16'hFFFF, 0,
                teq_pkg::KIND_IDLE, '0);
        put_row(teq_pkg::REQ_TICK,    48'd2233,       '0,           '0,       0,
                teq_pkg::KIND_FIRED, '0);
        put_row(teq_pkg::REQ_TICK,    48'd2234,       '0,           '0,       0,
                teq_pkg::KIND_FIRED, '0);
        put_row(teq_pkg::REQ_TICK,    TIME_MAX,       '0,           '0,       0,
                teq_pkg::KIND_FIRED, '0);
        put_row(teq_pkg::REQ_ADD_MS,  '0,             32'hFFFFFFFF, 16'h8001, 1,
                teq_pkg::KIND_ACCEPT, '0);
        put_row(teq_pkg::REQ_TICK,    TIME_MAX - 1,   '0,           '0,       0,
                teq_pkg::KIND_FIRED, '0);
        put_row(teq_pkg::REQ_TICK,    TIME_MAX,       '0,           '0,       1,
                teq_pkg::KIND_IDLE, TIME_MAX);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i]) send_word(script[i]);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            set_mode(phase_mode[p]);
            gap_pct = phase_gap[p];
            if (p % 2 == 0) fill_table();
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                make_random(r);
                send_word(r);
                maybe_gap();
            end
        end

        start <= 1'b0;
        while (owed_words.size() != 0) @(posedge clk);
        repeat (TAIL) @(posedge clk);

        $display("tb: %0d requests over %0d resolution phases, %0d mismatches", n_items,
                 PHASES + 1, mismatches);
        $display("tb: %0d timers fired, %0d adds refused on a full table, %0d empty ticks",
                 n_fired, n_reject, n_idle);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
